// File: rtl/lllc_pkg.sv
// ----------------------------------------------------------------------------
// lllc_pkg
// Shared types, constants and helpers for the log level line classifier.
// ----------------------------------------------------------------------------
package lllc_pkg;

	localparam int FIELDS_BEFORE_LEVEL = 4;
	localparam int COUNTER_WIDTH       = 32;
	localparam int FS_W                = $clog2(FIELDS_BEFORE_LEVEL + 2);
	localparam int NUM_CNT             = 8;
	localparam int CNT_IDX_W           = $clog2(NUM_CNT);
	localparam int EVQ_DEPTH           = 4;
	localparam int EVQ_PTR_W           = $clog2(EVQ_DEPTH);

	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_D   = 8'h44;
	localparam logic [7:0] CH_V   = 8'h56;
	localparam logic [7:0] CH_I   = 8'h49;
	localparam logic [7:0] CH_E   = 8'h45;
	localparam logic [7:0] CH_W   = 8'h57;

	typedef enum logic [2:0] {
		CLS_NONCONF = 3'd0,
		CLS_D       = 3'd1,
		CLS_V       = 3'd2,
		CLS_I       = 3'd3,
		CLS_E       = 3'd4,
		CLS_W       = 3'd5,
		CLS_UNKNOWN = 3'd6
	} class_t;

	// counter slots
	localparam logic [CNT_IDX_W-1:0] CNT_TOTAL   = CNT_IDX_W'(0);
	localparam logic [CNT_IDX_W-1:0] CNT_NONCONF = CNT_IDX_W'(1);

	typedef logic [COUNTER_WIDTH-1:0] cnt_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} in_t;

	typedef struct packed {
		logic [2:0]  line_class;
		logic [31:0] total_lines;
		logic [31:0] nonconforming_lines;
		logic [31:0] debug_lines;
		logic [31:0] verbose_lines;
		logic [31:0] info_lines;
		logic [31:0] error_lines;
		logic [31:0] warning_lines;
		logic [31:0] unknown_lines;
	} out_t;

	typedef struct packed {
		logic full;
		logic empty;
	} evq_stat_t;

	function automatic class_t lvl_class(input logic [7:0] ch);
		class_t c;
		unique case (ch)
			CH_D:    c = CLS_D;
			CH_V:    c = CLS_V;
			CH_I:    c = CLS_I;
			CH_E:    c = CLS_E;
			CH_W:    c = CLS_W;
			default: c = CLS_UNKNOWN;
		endcase
		return c;
	endfunction

	// counter slot that a line of this class bumps besides the total
	function automatic logic [CNT_IDX_W-1:0] cls_slot(input class_t c);
		logic [CNT_IDX_W-1:0] s;
		if (c == CLS_NONCONF) begin
			s = CNT_NONCONF;
		end else begin
			s = CNT_IDX_W'(c) + CNT_IDX_W'(1);
		end
		return s;
	endfunction

	// low 32 bits of a counter, zero extended when the counter is narrower
	function automatic logic [31:0] cnt_to_out(input cnt_t c);
		logic [COUNTER_WIDTH+31:0] ext;
		ext = {32'b0, c};
		return ext[31:0];
	endfunction

endpackage

// File: rtl/log_level_line_classifier_top.sv
// ----------------------------------------------------------------------------
// log_level_line_classifier_top
// Classifies text lines by the level character of their fifth field.
// ----------------------------------------------------------------------------
// Bytes enter one per clock; full only rises when the four-entry event queue
// is full, which happens only while results sit unpopped. Each LF (or an end
// marker that closes a partial line) yields one result: the line class and
// the eight saturating line counters after that line. A result reaches the
// output through the event queue and then the counter unit's output
// register, which loads it once that register is empty or being popped. The
// counter unit retires one line per cycle while results are popped as they
// come, so the sustained rate is one item per cycle.
module log_level_line_classifier_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  lllc_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output lllc_pkg::out_t result
);
	import lllc_pkg::*;

	logic      evq_wr;
	class_t    evq_wr_class;
	logic      evq_rd;
	class_t    evq_rd_class;
	evq_stat_t evq_stat;

	lllc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.evq_full  (evq_stat.full),
		.evq_push  (evq_wr),
		.evq_class (evq_wr_class)
	);

	lllc_evq u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (evq_wr),
		.wr_class (evq_wr_class),
		.rd       (evq_rd),
		.rd_class (evq_rd_class),
		.stat     (evq_stat)
	);

	lllc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.evq_stat  (evq_stat),
		.evq_class (evq_rd_class),
		.evq_pop   (evq_rd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// an accepted newline always leaves an event queued or already taken
	a_lf_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !item.stream_end && item.data_byte == CH_LF)
		|=> !evq_stat.empty || !empty)
		else $error("newline beat lost before counter unit");

	// popping with an event waiting refills the output at once
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !evq_stat.empty) |=> !empty)
		else $error("output register not refilled from waiting event");

	// scanner stalls only when the event queue is full
	a_full_src: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !evq_stat.empty)
		else $error("full raised with empty event queue");

endmodule

// File: rtl/lllc_front.sv
// ----------------------------------------------------------------------------
// lllc_front
// Byte scanner: tracks fields within a line and posts one class event per
// ended line into the event queue.
// ----------------------------------------------------------------------------
module lllc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  lllc_pkg::in_t  item,
	input  logic           evq_full,
	output logic           evq_push,
	output lllc_pkg::class_t evq_class
);
	import lllc_pkg::*;

	logic [FS_W-1:0] fields_started_q;
	logic            inside_field_q;
	logic            content_closed_q;
	logic            line_pending_q;
	class_t          level_found_q;

	logic accept;
	logic line_end;

	assign full   = evq_full;
	assign accept = push && !evq_full;

	always_comb begin
		if (item.stream_end) begin
			line_end = line_pending_q;
		end else begin
			line_end = (item.data_byte == CH_LF);
		end
	end

	assign evq_push  = accept && line_end;
	assign evq_class = level_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_started_q <= '0;
			inside_field_q   <= 1'b0;
			content_closed_q <= 1'b0;
			line_pending_q   <= 1'b0;
			level_found_q    <= CLS_NONCONF;
		end else if (accept) begin
			if (line_end) begin
				fields_started_q <= '0;
				inside_field_q   <= 1'b0;
				content_closed_q <= 1'b0;
				line_pending_q   <= 1'b0;
				level_found_q    <= CLS_NONCONF;
			end else if (!item.stream_end) begin
				line_pending_q <= 1'b1;
				if (!content_closed_q) begin
					if (item.data_byte == CH_CR || item.data_byte == CH_NUL) begin
						content_closed_q <= 1'b1;
						inside_field_q   <= 1'b0;
					end else if (item.data_byte == CH_SP) begin
						inside_field_q <= 1'b0;
					end else if (!inside_field_q) begin
						// first byte of a new field
						if (fields_started_q == FS_W'(FIELDS_BEFORE_LEVEL)) begin
							level_found_q <= lvl_class(item.data_byte);
						end
						if (fields_started_q <= FS_W'(FIELDS_BEFORE_LEVEL)) begin
							fields_started_q <= fields_started_q + FS_W'(1);
						end
						inside_field_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: rtl/lllc_evq.sv
// ----------------------------------------------------------------------------
// lllc_evq
// Short queue of line class events between the scanner and the counter unit.
// ----------------------------------------------------------------------------
module lllc_evq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  lllc_pkg::class_t   wr_class,
	input  logic               rd,
	output lllc_pkg::class_t   rd_class,
	output lllc_pkg::evq_stat_t stat
);
	import lllc_pkg::*;

	class_t                mem [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0]  wr_ptr_q;
	logic [EVQ_PTR_W-1:0]  rd_ptr_q;
	logic [EVQ_PTR_W:0]    count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign stat.full  = (count_q == (EVQ_PTR_W+1)'(EVQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_class   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_class;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + EVQ_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (EVQ_PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (EVQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

// File: rtl/lllc_back.sv
// ----------------------------------------------------------------------------
// lllc_back
// Counter unit: bumps the saturating line counters for each class event and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module lllc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lllc_pkg::evq_stat_t evq_stat,
	input  lllc_pkg::class_t    evq_class,
	output logic                evq_pop,
	output logic                empty,
	input  logic                pop,
	output lllc_pkg::out_t      result
);
	import lllc_pkg::*;

	cnt_t                 cnt_q [NUM_CNT];
	cnt_t                 cnt_nxt [NUM_CNT];
	logic                 out_valid_q;
	out_t                 out_q;
	logic                 take;
	logic [CNT_IDX_W-1:0] slot;

	assign take    = !evq_stat.empty && (!out_valid_q || pop);
	assign evq_pop = take;
	assign slot    = cls_slot(evq_class);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_comb begin
		for (int i = 0; i < NUM_CNT; i++) begin
			if ((CNT_IDX_W'(i) == CNT_TOTAL || CNT_IDX_W'(i) == slot) && !(&cnt_q[i])) begin
				cnt_nxt[i] = cnt_q[i] + COUNTER_WIDTH'(1);
			end else begin
				cnt_nxt[i] = cnt_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (take) begin
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.line_class          <= evq_class;
			out_q.total_lines         <= cnt_to_out(cnt_nxt[0]);
			out_q.nonconforming_lines <= cnt_to_out(cnt_nxt[1]);
			out_q.debug_lines         <= cnt_to_out(cnt_nxt[2]);
			out_q.verbose_lines       <= cnt_to_out(cnt_nxt[3]);
			out_q.info_lines          <= cnt_to_out(cnt_nxt[4]);
			out_q.error_lines         <= cnt_to_out(cnt_nxt[5]);
			out_q.warning_lines       <= cnt_to_out(cnt_nxt[6]);
			out_q.unknown_lines       <= cnt_to_out(cnt_nxt[7]);
		end
	end

endmodule
